### rtl/y86_pkg.sv
// ----------------------------------------------------------------------------
// y86_pkg: shared types and constants for the Y86 instruction executor
// Opcodes, status codes, output kinds and controller/datapath signal bundles.
// ----------------------------------------------------------------------------
package y86_pkg;

  localparam int DataW = 32;
  localparam int PcW = 12;

  // opcodes
  localparam logic [7:0] OpNop    = 8'h00;
  localparam logic [7:0] OpHalt   = 8'h10;
  localparam logic [7:0] OpRrmov  = 8'h20;
  localparam logic [7:0] OpIrmov  = 8'h30;
  localparam logic [7:0] OpRmmov  = 8'h40;
  localparam logic [7:0] OpMrmov  = 8'h50;
  localparam logic [7:0] OpAdd    = 8'h60;
  localparam logic [7:0] OpSub    = 8'h61;
  localparam logic [7:0] OpAnd    = 8'h62;
  localparam logic [7:0] OpMul    = 8'h64;
  localparam logic [7:0] OpCmp    = 8'h65;
  localparam logic [7:0] OpJmp    = 8'h70;
  localparam logic [7:0] OpJe     = 8'h73;
  localparam logic [7:0] OpJne    = 8'h74;
  localparam logic [7:0] OpCall   = 8'h80;
  localparam logic [7:0] OpRet    = 8'h90;
  localparam logic [7:0] OpPush   = 8'ha0;
  localparam logic [7:0] OpPop    = 8'hb0;
  localparam logic [7:0] OpRead   = 8'hc1;
  localparam logic [7:0] OpWritel = 8'hd1;
  localparam logic [7:0] OpWriteb = 8'hd0;
  localparam logic [7:0] OpMovsb  = 8'he0;

  // status codes
  localparam logic [2:0] StRun    = 3'd0;
  localparam logic [2:0] StHalt   = 3'd1;
  localparam logic [2:0] StBadReg = 3'd2;
  localparam logic [2:0] StBadIns = 3'd3;
  localparam logic [2:0] StRange  = 3'd4;

  // output kinds
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindWord = 2'd1;
  localparam logic [1:0] KindByte = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgStartPc = 2'd0;
  localparam logic [1:0] CfgReadMin = 2'd1;
  localparam logic [1:0] CfgReadMax = 2'd2;

  localparam logic [2:0] SpReg = 3'd4;

  // datapath operations
  typedef enum logic [3:0] {
    DpIdle,     // nothing
    DpLoad,     // write load byte
    DpTake,     // capture readl operands of an accepted step item
    DpStart,    // latch pc, reset fetch
    DpFetch,    // read instruction byte (cnt)
    DpDecode,   // check registers, compute address
    DpMemRd,    // read data byte (cnt)
    DpMemWr,    // write data byte (cnt)
    DpFinish    // commit registers, pc, flag, status
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic need_rd;   // instruction reads memory data
    logic need_wr;   // instruction writes memory data
    logic rd_byte;   // read only one byte
    logic stop;      // decode found an error or halt, skip memory
    logic running;   // status is running
    logic busy;      // memory clearing pass after reset
  } dp_stat_t;

endpackage

### rtl/y86_if.sv
// ----------------------------------------------------------------------------
// y86_if: valid/ready channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface y86_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] load_addr;
  logic [7:0]  load_data;
  logic signed [31:0] in_value;
  logic        in_eof;
  modport source (output valid, cmd, load_addr, load_data, in_value, in_eof,
                  input ready);
  modport sink (input valid, cmd, load_addr, load_data, in_value, in_eof,
                output ready);
endinterface

interface y86_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  out_kind;
  logic signed [31:0] out_value;
  logic [11:0] next_pc;
  logic        zero_flag;
  modport source (output valid, status, out_kind, out_value, next_pc, zero_flag,
                  input ready);
  modport sink (input valid, status, out_kind, out_value, next_pc, zero_flag,
                output ready);
endinterface

interface y86_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/y86_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// y86_instruction_executor_top: sequential Y86 executor
// Load items write memory bytes; step items run one instruction.
// ----------------------------------------------------------------------------
// After reset the block zero-fills all 2^MEM_ADDR_BITS bytes of its memory
// (4096 by default), one byte per cycle, before it takes the first item.
// A load item's result is valid the cycle after it is accepted. For a step
// item, six instruction bytes are fetched one per cycle over the memory read
// port, the last one landing in a closing wait step; then any data bytes of a
// byte read, word read or word write are read or written one per cycle, then
// results are committed. A step on a stopped core goes straight from its
// start step to the output step.
// One item is in flight at a time; the result register holds until taken.
module y86_instruction_executor_top #(
  parameter int MEM_ADDR_BITS = 12
) (
  input logic        clk,
  input logic        rst,
  y86_in_if.sink     in_ch,
  y86_out_if.source  out_ch,
  y86_cfg_if.sink    cfg
);
  import y86_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     res_valid;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  y86_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
    .stat(stat), .cmd(cmd),
    .res_valid(res_valid), .res_ready(out_ch.ready)
  );

  y86_dpath #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .load_addr(in_ch.load_addr), .load_data(in_ch.load_data),
    .in_value(in_ch.in_value), .in_eof(in_ch.in_eof),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .status(out_ch.status), .out_kind(out_ch.out_kind),
    .out_value(out_ch.out_value), .next_pc(out_ch.next_pc),
    .zero_flag(out_ch.zero_flag)
  );

  assign out_ch.valid = res_valid;
endmodule

### rtl/y86_ctrl.sv
// ----------------------------------------------------------------------------
// y86_ctrl: sequencing controller
// Walks each step item through fetch, decode, memory and commit steps.
// ----------------------------------------------------------------------------
module y86_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  y86_pkg::dp_stat_t stat,
  output y86_pkg::dp_cmd_t  cmd,
  output logic              res_valid,
  input  logic              res_ready
);
  import y86_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_FETCH, S_DECODE, S_MEM, S_FINISH, S_OUT
  } state_t;

  state_t     state;
  logic [2:0] cnt;
  logic       rd_done;   // last read byte has landed

  assign in_ready  = (state == S_IDLE) && !res_valid && !stat.busy;
  assign cmd.cnt   = cnt;
  assign rd_done   = (cnt == 3'd4) || (stat.rd_byte && cnt == 3'd1);

  // command for current step
  always_comb begin
    case (state)
      S_START:  cmd.op = DpStart;
      S_FETCH:  cmd.op = (cnt == 3'd6) ? DpIdle : DpFetch;
      S_DECODE: cmd.op = DpDecode;
      S_MEM:    cmd.op = stat.need_wr ? DpMemWr : (rd_done ? DpIdle : DpMemRd);
      S_FINISH: cmd.op = DpFinish;
      S_IDLE:   cmd.op = (in_valid && in_ready) ? (in_cmd ? DpTake : DpLoad) : DpIdle;
      default:  cmd.op = DpIdle;
    endcase
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_cmd) state <= S_START;
            else res_valid <= 1'b1;
          end
        end
        S_START: begin
          cnt <= '0;
          state <= stat.running ? S_FETCH : S_OUT;
        end
        S_FETCH: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6) state <= S_DECODE;
        end
        S_DECODE: begin
          cnt <= '0;
          if (stat.stop || !(stat.need_rd || stat.need_wr)) state <= S_FINISH;
          else state <= S_MEM;
        end
        S_MEM: begin
          cnt <= cnt + 3'd1;
          if (stat.need_wr ? (cnt == 3'd3) : rd_done) state <= S_FINISH;
        end
        S_FINISH: state <= S_OUT;
        S_OUT: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result only raised from idle or output step
  a_res_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_OUT || $past(state) == S_IDLE))
    else $error("result raised mid-step");
  a_fetch_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE) |-> ($past(state) == S_FETCH))
    else $error("decode without fetch");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("accept while busy");
endmodule

### rtl/y86_dpath.sv
// ----------------------------------------------------------------------------
// y86_dpath: datapath of the Y86 executor
// Byte memory, register file, pc, flag, status and result registers.
// ----------------------------------------------------------------------------
module y86_dpath #(
  parameter int MEM_ADDR_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  y86_pkg::dp_cmd_t    cmd,
  output y86_pkg::dp_stat_t   stat,
  input  logic [11:0]         load_addr,
  input  logic [7:0]          load_data,
  input  logic signed [31:0]  in_value,
  input  logic                in_eof,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic [2:0]          status,
  output logic [1:0]          out_kind,
  output logic [31:0]         out_value,
  output logic [11:0]         next_pc,
  output logic                zero_flag
);
  import y86_pkg::*;

  localparam int AW = MEM_ADDR_BITS;
  localparam int MemDepth = 1 << AW;

  logic [7:0]  mem [MemDepth];
  logic [31:0] rf [8];
  logic [AW-1:0] pc;
  logic        pc_loaded;
  logic [11:0] start_pc;
  logic [15:0] read_min, read_max;
  logic [7:0]  ib [6];
  logic [AW-1:0] addr;     // data address
  logic [31:0] wdata;      // store word
  logic [31:0] rword;      // loaded word
  logic [7:0]  rbyte;
  logic        bad;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;
  logic [31:0] prod;
  logic signed [31:0] in_val_q;   // readl operand of the current step
  logic        in_eof_q;
  logic        clearing;          // zero-fill pass after reset
  logic [AW-1:0] clr_addr;

  logic [7:0]  op;
  logic [3:0]  ra_n, rb_n;
  logic [2:0]  ra, rb;
  logic [31:0] dval, va, vb, sp, base, sp_m4;
  logic [AW-1:0] dest;
  logic        need_a, need_b, known;
  logic        wr_word, rd_word;

  assign op   = ib[0];
  assign ra_n = ib[1][7:4];
  assign rb_n = ib[1][3:0];
  assign ra   = ra_n[2:0];
  assign rb   = rb_n[2:0];
  assign dval = {ib[5], ib[4], ib[3], ib[2]};
  assign dest = AW'({ib[4], ib[3], ib[2], ib[1]});
  assign va   = rf[ra];
  assign vb   = rf[rb];
  assign sp   = rf[SpReg];
  assign sp_m4 = sp - 32'd4;
  assign base = (op == OpMovsb || op == OpRmmov || op == OpMrmov) ? vb : va;

  // decode register use and memory traffic
  always_comb begin
    need_a = 1'b0; need_b = 1'b0; known = 1'b1;
    rd_word = 1'b0; wr_word = 1'b0;
    case (op)
      OpRrmov, OpAdd, OpSub, OpAnd, OpMul, OpCmp: begin
        need_a = 1'b1; need_b = 1'b1;
      end
      OpRmmov: begin need_a = 1'b1; need_b = 1'b1; wr_word = 1'b1; end
      OpMrmov: begin need_a = 1'b1; need_b = 1'b1; rd_word = 1'b1; end
      OpMovsb: begin need_a = 1'b1; need_b = 1'b1; rd_word = 1'b1; end
      OpIrmov: need_b = 1'b1;
      OpPush:  begin need_a = 1'b1; wr_word = 1'b1; end
      OpPop:   begin need_a = 1'b1; rd_word = 1'b1; end
      OpRead:  begin need_a = 1'b1; wr_word = 1'b1; end
      OpWritel, OpWriteb: begin need_a = 1'b1; rd_word = 1'b1; end
      OpCall:  wr_word = 1'b1;
      OpRet:   rd_word = 1'b1;
      OpNop, OpHalt, OpJmp, OpJe, OpJne: ;
      default: known = 1'b0;
    endcase
  end

  // flag a register nibble above 7 in a field the instruction uses
  assign bad = (need_a && ra_n[3]) || (need_b && rb_n[3]);

  logic rd_ok;   // readl value in range
  assign rd_ok = !in_val_q[31] && (in_val_q <= $signed({16'd0, read_max}))
                 && (in_val_q >= $signed({16'd0, read_min}));

  assign stat.need_rd = rd_word;
  assign stat.need_wr = wr_word && !(op == OpRead && (in_eof_q || !rd_ok));
  assign stat.rd_byte = (op == OpWriteb) || (op == OpMovsb);
  assign stat.stop    = bad || !known || op == OpHalt;
  assign stat.running = (status == StRun);
  assign stat.busy    = clearing;

  // walk every memory address once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (&clr_addr) clearing <= 1'b0;
    end
  end

  // memory address mux
  always_comb begin
    mem_we = 1'b0; mem_wa = addr + AW'(cmd.cnt); mem_wd = wdata[7:0];
    mem_ra = pc + AW'(cmd.cnt);
    if (clearing) begin
      mem_we = 1'b1; mem_wa = clr_addr; mem_wd = 8'd0;
    end else begin
      case (cmd.op)
        DpLoad: begin
          mem_we = 1'b1; mem_wa = AW'(load_addr); mem_wd = load_data;
        end
        DpMemWr: begin
          mem_we = 1'b1;
          case (cmd.cnt[1:0])
            2'd0:    mem_wd = wdata[7:0];
            2'd1:    mem_wd = wdata[15:8];
            2'd2:    mem_wd = wdata[23:16];
            default: mem_wd = wdata[31:24];
          endcase
        end
        DpMemRd: mem_ra = addr + AW'(cmd.cnt);
        default: ;
      endcase
    end
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rbyte <= mem[mem_ra];
  end

  logic       rd_pend;  // a read byte is arriving
  logic [2:0] rd_slot;
  logic       rd_is_fetch;

  always_ff @(posedge clk) begin
    prod <= va * vb;
    if (rst) rd_pend <= 1'b0;
    else rd_pend <= (cmd.op == DpFetch) || (cmd.op == DpMemRd);
    rd_slot <= cmd.cnt;
    rd_is_fetch <= (cmd.op == DpFetch);
    if (rd_pend) begin
      if (rd_is_fetch) ib[rd_slot] <= rbyte;
      else begin
        case (rd_slot[1:0])
          2'd0:    rword <= {24'd0, rbyte};
          2'd1:    rword[15:8] <= rbyte;
          2'd2:    rword[23:16] <= rbyte;
          default: rword[31:24] <= rbyte;
        endcase
      end
    end
  end

  // sequence the register/pc state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) rf[i] <= '0;
      pc <= '0; pc_loaded <= 1'b0; zero_flag <= 1'b0; status <= StRun;
      start_pc <= '0; read_min <= 16'd1; read_max <= 16'd12;
      out_kind <= KindNone; out_value <= '0;
      in_val_q <= '0; in_eof_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgStartPc: start_pc <= cfg_data[11:0];
          CfgReadMin: read_min <= cfg_data;
          CfgReadMax: read_max <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        DpLoad: begin out_kind <= KindNone; out_value <= '0; end
        DpTake: begin in_val_q <= in_value; in_eof_q <= in_eof; end
        DpStart: begin
          out_kind <= KindNone; out_value <= '0;
          if (!pc_loaded && status == StRun) begin
            pc <= AW'(start_pc); pc_loaded <= 1'b1;
          end
        end
        DpDecode: begin
          case (op)
            OpCall, OpPush: addr <= AW'(sp_m4);
            OpRet, OpPop:   addr <= AW'(sp);
            default:        addr <= AW'(base + dval);
          endcase
          case (op)
            OpCall:  wdata <= 32'(AW'(pc + AW'(5)));
            OpRead:  wdata <= in_val_q;
            OpRmmov: wdata <= va;
            default: wdata <= va;
          endcase
        end
        DpFinish: begin
          if (bad && known) status <= StBadReg;
          else begin
            case (op)
              OpNop: pc <= pc + AW'(1);
              OpHalt: status <= StHalt;
              OpRrmov: begin rf[rb] <= va; pc <= pc + AW'(2); end
              OpIrmov: begin rf[rb] <= dval; pc <= pc + AW'(6); end
              OpRmmov: pc <= pc + AW'(6);
              OpMrmov: begin rf[ra] <= rword; pc <= pc + AW'(6); end
              OpAdd, OpSub, OpAnd, OpMul: begin
                logic [31:0] r;
                r = (op == OpAdd) ? vb + va : (op == OpSub) ? vb - va :
                    (op == OpAnd) ? (vb & va) : prod;
                rf[rb] <= r; zero_flag <= (r == 32'd0); pc <= pc + AW'(2);
              end
              OpCmp: begin zero_flag <= (vb == va); pc <= pc + AW'(2); end
              OpJmp: pc <= dest;
              OpJe:  pc <= zero_flag ? dest : pc + AW'(5);
              OpJne: pc <= !zero_flag ? dest : pc + AW'(5);
              OpCall: begin rf[SpReg] <= sp_m4; pc <= dest; end
              OpRet: begin pc <= AW'(rword); rf[SpReg] <= sp + 32'd4; end
              OpPush: begin rf[SpReg] <= sp_m4; pc <= pc + AW'(2); end
              OpPop: begin
                // popping into the stack pointer keeps the popped value
                rf[ra] <= rword; pc <= pc + AW'(2);
                if (ra != SpReg) rf[SpReg] <= sp + 32'd4;
              end
              OpRead: begin
                if (in_eof_q) begin zero_flag <= 1'b1; status <= StHalt; end
                else if (!rd_ok) status <= StRange;
                else begin zero_flag <= 1'b0; pc <= pc + AW'(6); end
              end
              OpWritel: begin
                out_kind <= KindWord; out_value <= rword; pc <= pc + AW'(6);
              end
              OpWriteb: begin
                out_kind <= KindByte; out_value <= {24'd0, rword[7:0]};
                pc <= pc + AW'(6);
              end
              OpMovsb: begin
                rf[ra] <= {{24{rword[7]}}, rword[7:0]}; pc <= pc + AW'(6);
              end
              default: status <= StBadIns;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign next_pc = pc_loaded ? 12'(pc) : 12'(AW'(start_pc));

  a_status_holds: assert property (@(posedge clk) disable iff (rst)
    ($past(status) != StRun) |-> (status == $past(status)))
    else $error("stopped status changed");
  a_loaded_stays: assert property (@(posedge clk) disable iff (rst)
    $past(pc_loaded) |-> pc_loaded)
    else $error("pc load flag dropped");
  a_kind_value: assert property (@(posedge clk) disable iff (rst)
    (out_kind == KindNone) |-> (out_value == 32'd0))
    else $error("value without kind");
endmodule

### sim/y86_instruction_executor_top_tb.sv
// ----------------------------------------------------------------------------
// y86_instruction_executor_top_tb: self-checking bench for the Y86 executor
// Builds instructions in memory with load items at the program
// counter, then steps them. A scoreboard predicts each result.
// Idle and stall rates vary by phase. One receiver hold-off fills the block.
// The run ends with a stopping instruction, then loads and steps after it.
// ----------------------------------------------------------------------------
module y86_instruction_executor_top_tb;
  import y86_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [11:0] pc;
    logic        zf;
  } exec_result_t;

  // Instruction-level model of the executor and its queue of expected items
  class y86_exec_scoreboard;
    bit [7:0]  mem [4096];
    bit [31:0] rf [8];
    bit [11:0] pc;
    bit        pc_loaded;
    bit        zf;
    bit [2:0]  st;
    bit [11:0] start_pc;
    bit [15:0] rmin;
    bit [15:0] rmax;
    exec_result_t pending [$];
    int        fails;

    function new();
      rmin = 16'd1;
      rmax = 16'd12;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CfgStartPc: start_pc = data[11:0];
        CfgReadMin: rmin = data;
        CfgReadMax: rmax = data;
        default: ;
      endcase
    endfunction

    function bit [11:0] cur_pc();
      return pc_loaded ? pc : start_pc;
    endfunction

    function bit [31:0] rd32(bit [31:0] a);
      return {mem[12'(a + 3)], mem[12'(a + 2)], mem[12'(a + 1)], mem[12'(a)]};
    endfunction

    function void wr32(bit [31:0] a, bit [31:0] v);
      for (int k = 0; k < 4; k++) mem[12'(a + k)] = v[8*k +: 8];
    endfunction

    // Run one instruction at the current pc
    function void execute(bit [31:0] val, bit eof, output bit [1:0] kind,
                          output bit [31:0] outv);
      bit [31:0] p, d, r, sp;
      bit [11:0] dest;
      bit [7:0]  op, spec;
      bit [3:0]  ra, rb;
      bit        need_a, need_b;
      int        v;
      kind = KindNone;
      outv = 0;
      p = pc;
      op = mem[pc];
      spec = mem[12'(pc + 1)];
      ra = spec[7:4];
      rb = spec[3:0];
      d = rd32(p + 2);
      dest = 12'(rd32(p + 1));
      need_a = 0;
      need_b = 0;
      case (op)
        OpRrmov, OpRmmov, OpMrmov, OpAdd, OpSub, OpAnd, OpMul, OpCmp, OpMovsb: begin
          need_a = 1;
          need_b = 1;
        end
        OpIrmov: need_b = 1;
        OpPush, OpPop, OpRead, OpWritel, OpWriteb: need_a = 1;
        default: ;
      endcase
      if ((need_a && ra > 7) || (need_b && rb > 7)) begin
        st = StBadReg;
        return;
      end
      ra[3] = 0;
      rb[3] = 0;
      case (op)
        OpNop: p += 1;
        OpHalt: st = StHalt;
        OpRrmov: begin
          rf[rb] = rf[ra];
          p += 2;
        end
        OpIrmov: begin
          rf[rb] = d;
          p += 6;
        end
        OpRmmov: begin
          wr32(rf[rb] + d, rf[ra]);
          p += 6;
        end
        OpMrmov: begin
          rf[ra] = rd32(rf[rb] + d);
          p += 6;
        end
        OpAdd, OpSub, OpAnd, OpMul: begin
          if (op == OpAdd) r = rf[rb] + rf[ra];
          else if (op == OpSub) r = rf[rb] - rf[ra];
          else if (op == OpAnd) r = rf[rb] & rf[ra];
          else r = rf[rb] * rf[ra];
          rf[rb] = r;
          zf = (r == 0);
          p += 2;
        end
        OpCmp: begin
          zf = (rf[rb] - rf[ra] == 0);
          p += 2;
        end
        OpJmp: p = dest;
        OpJe: p = zf ? dest : p + 5;
        OpJne: p = !zf ? dest : p + 5;
        OpCall: begin
          rf[SpReg] -= 4;
          wr32(rf[SpReg], 12'(p + 5));
          p = dest;
        end
        OpRet: begin
          p = rd32(rf[SpReg]);
          rf[SpReg] += 4;
        end
        OpPush: begin
          r = rf[ra];
          rf[SpReg] -= 4;
          wr32(rf[SpReg], r);
          p += 2;
        end
        OpPop: begin
          sp = rf[SpReg];
          rf[SpReg] = sp + 4;
          rf[ra] = rd32(sp);
          p += 2;
        end
        OpRead: begin
          v = val;
          if (eof) begin
            zf = 1;
            st = StHalt;
          end else if (v < int'(rmin) || v > int'(rmax)) begin
            st = StRange;
          end else begin
            zf = 0;
            wr32(rf[ra] + d, val);
            p += 6;
          end
        end
        OpWritel: begin
          kind = KindWord;
          outv = rd32(rf[ra] + d);
          p += 6;
        end
        OpWriteb: begin
          kind = KindByte;
          outv = mem[12'(rf[ra] + d)];
          p += 6;
        end
        OpMovsb: begin
          r = mem[12'(rf[rb] + d)];
          rf[ra] = r[7] ? (r | 32'hffffff00) : r;
          p += 6;
        end
        default: st = StBadIns;
      endcase
      pc = p[11:0];
    endfunction

    // Predict the result of one accepted input item
    function void note_item(bit cmd, bit [11:0] addr, bit [7:0] data,
                            bit [31:0] val, bit eof);
      exec_result_t e;
      bit [1:0]  kind;
      bit [31:0] outv;
      kind = KindNone;
      outv = 0;
      if (!cmd) begin
        mem[addr] = data;
      end else if (st == StRun) begin
        if (!pc_loaded) begin
          pc = start_pc;
          pc_loaded = 1;
        end
        execute(val, eof, kind, outv);
      end
      e.status = st;
      e.kind = kind;
      e.value = outv;
      e.pc = cur_pc();
      e.zf = zf;
      pending.push_back(e);
    endfunction

    function void check_result(exec_result_t a);
      exec_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %h pc %h", $time, a.status, a.pc);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status exp %h act %h", $time, e.status, a.status);
        fails++;
      end
      if (a.kind !== e.kind) begin
        $display("%0t: out_kind exp %h act %h", $time, e.kind, a.kind);
        fails++;
      end
      if (a.value !== e.value) begin
        $display("%0t: out_value exp %h act %h", $time, e.value, a.value);
        fails++;
      end
      if (a.pc !== e.pc) begin
        $display("%0t: next_pc exp %h act %h", $time, e.pc, a.pc);
        fails++;
      end
      if (a.zf !== e.zf) begin
        $display("%0t: zero_flag exp %h act %h", $time, e.zf, a.zf);
        fails++;
      end
    endfunction
  endclass

  localparam int WatchLimit = 20000;
  localparam int ItemTarget = 1600;

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_stall;
  logic hold_off;
  int   quiet;
  int   items_sent;
  y86_exec_scoreboard sb;

  y86_in_if  in_ch ();
  y86_out_if out_ch ();
  y86_cfg_if cfg ();

  y86_instruction_executor_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Drain results with random stalls and check each one
  always @(posedge clk) begin
    exec_result_t a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a.status = out_ch.status;
      a.kind = out_ch.out_kind;
      a.value = out_ch.out_value;
      a.pc = out_ch.next_pc;
      a.zf = out_ch.zero_flag;
      sb.check_result(a);
    end
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // Count cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("** y86_instruction_executor_top: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(bit cmd, bit [11:0] addr, bit [7:0] data,
                           bit [31:0] val, bit eof);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.load_addr <= addr;
    in_ch.load_data <= data;
    in_ch.in_value <= val;
    in_ch.in_eof <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(cmd, addr, data, val, eof);
    items_sent++;
  endtask

  // Let the block go idle, then write one register
  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    sb.write_reg(idx, data);
  endtask

  // Place one instruction at the pc with load items, then step it.
  // mode: 0 normal, 1 bad register, 2 end of input, 3 input out of range
  task automatic run_instr(logic [7:0] op, int mode);
    bit [7:0]  b [6];
    bit [11:0] at;
    bit [31:0] val;
    bit        na, nb;
    int        len;
    for (int k = 1; k < 6; k++) b[k] = 8'($urandom);
    b[0] = op;
    na = 0;
    nb = 0;
    case (op)
      OpRrmov, OpRmmov, OpMrmov, OpAdd, OpSub, OpAnd, OpMul, OpCmp, OpMovsb: begin
        na = 1;
        nb = 1;
      end
      OpIrmov: nb = 1;
      OpPush, OpPop, OpRead, OpWritel, OpWriteb: na = 1;
      default: ;
    endcase
    if (na) b[1][7] = 0;
    if (nb) b[1][3] = 0;
    if (mode == 1) begin
      if (na && (!nb || $urandom_range(1))) b[1][7] = 1;
      else b[1][3] = 1;
    end
    case (op)
      OpNop, OpHalt, OpRet: len = 1;
      OpRrmov, OpAdd, OpSub, OpAnd, OpMul, OpCmp, OpPush, OpPop: len = 2;
      OpJmp, OpJe, OpJne, OpCall: len = 5;
      OpIrmov, OpRmmov, OpMrmov, OpRead, OpWritel, OpWriteb, OpMovsb: len = 6;
      default: len = 1;
    endcase
    // occasional stray loads before the code is placed
    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
      send_item(0, 12'($urandom), 8'($urandom), $urandom, 1'($urandom));
    at = sb.cur_pc();
    for (int k = 0; k < len; k++)
      send_item(0, 12'(at + k), b[k], $urandom, 1'($urandom));
    if (op == OpRead) begin
      if (mode == 3) val = $urandom | 32'h80000000;
      else val = $urandom_range(sb.rmax, sb.rmin);
      send_item(1, 12'($urandom), 8'($urandom), val, mode == 2);
    end else begin
      send_item(1, 12'($urandom), 8'($urandom), $urandom, 1'($urandom));
    end
  endtask

  task automatic random_instr();
    logic [7:0] ops [21];
    ops = '{OpNop, OpRrmov, OpIrmov, OpRmmov, OpMrmov, OpAdd, OpSub, OpAnd, OpMul,
            OpCmp, OpJmp, OpJe, OpJne, OpCall, OpRet, OpPush, OpPop, OpRead,
            OpWritel, OpWriteb, OpMovsb};
    // run compares often to update the flag that the branches test
    if ($urandom_range(5) == 0) run_instr(OpCmp, 0);
    else run_instr(ops[$urandom_range(20)], 0);
  endtask

  initial begin
    logic [7:0] dir_ops [21];
    logic [15:0] lo, hi;
    int stop_kind;
    sb = new();
    rst = 1;
    hold_off = 0;
    send_idle = 0;
    recv_stall = 0;
    items_sent = 0;
    in_ch.valid = 0;
    in_ch.cmd = 0;
    in_ch.load_addr = 0;
    in_ch.load_data = 0;
    in_ch.in_value = 0;
    in_ch.in_eof = 0;
    out_ch.ready = 0;
    cfg.valid = 0;
    cfg.index = CfgStartPc;
    cfg.data = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, a wrapping start address, every operation but halt
    send_item(0, 12'h000, 8'h00, 32'h80000000, 1);
    send_item(0, 12'hfff, 8'hff, 32'h7fffffff, 0);
    write_cfg(CfgReadMin, 16'h0000);
    write_cfg(CfgReadMax, 16'hffff);
    write_cfg(CfgStartPc, 16'h0ffe);
    send_item(0, 12'h800, 8'h5a, 32'hffffffff, 0);
    dir_ops = '{OpIrmov, OpNop, OpRrmov, OpRmmov, OpMrmov, OpAdd, OpSub, OpAnd,
                OpMul, OpCmp, OpJe, OpJne, OpJmp, OpCall, OpRet, OpPush, OpPop,
                OpRead, OpWritel, OpWriteb, OpMovsb};
    foreach (dir_ops[i]) run_instr(dir_ops[i], 0);
    // start address written after the first step must not move the pc
    write_cfg(CfgStartPc, 16'h0fff);
    run_instr(OpRead, 0);

    // random: four phases, each with its own readl window
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          lo = 16'h0000;
          hi = 16'hffff;
        end
        1: begin
          lo = 16'($urandom);
          hi = 16'($urandom_range(16'hffff, lo));
        end
        2: begin
          lo = 16'($urandom);
          hi = lo;
        end
        default: begin
          lo = 16'hffff;
          hi = 16'hffff;
        end
      endcase
      write_cfg(CfgReadMin, lo);
      write_cfg(CfgReadMax, hi);
      send_idle = (ph == 1) ? 85 : (ph == 3) ? 16 : 0;
      recv_stall = (ph == 2) ? 85 : (ph == 3) ? 16 : 0;
      if (ph == 0) begin
        fork
          begin
            hold_off <= 1;
            repeat (400) @(posedge clk);
            hold_off <= 0;
          end
        join_none
      end
      while (items_sent < ItemTarget * (ph + 1) / 4) random_instr();
    end

    // stop the core one way, then show that steps do nothing and loads still land
    stop_kind = $urandom_range(4);
    case (stop_kind)
      0: run_instr(OpHalt, 0);
      1: run_instr(OpAdd, 1);
      2: run_instr(8'hf0, 0);
      3: run_instr(OpRead, 2);
      default: run_instr(OpRead, 3);
    endcase
    repeat (3) random_instr();
    send_item(0, sb.cur_pc(), OpNop, 0, 0);
    send_item(1, 0, 0, 0, 0);
    in_ch.valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("** y86_instruction_executor_top: PASSED **");
    end else begin
      $display("** y86_instruction_executor_top: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/y86_pkg.sv
rtl/y86_if.sv
rtl/y86_ctrl.sv
rtl/y86_dpath.sv
rtl/y86_instruction_executor_top.sv
sim/y86_instruction_executor_top_tb.sv
